// File: hdl/eqmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eqmf_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int PAYLOAD_W_DEF = 32;

  localparam logic [7:0] TYPE_LIMIT  = 8'd32;
  localparam logic [5:0] MAX_RESULTS = 6'd63;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_TAKE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  event_type;
    logic [31:0] event_payload;
    logic [31:0] type_mask;
    logic [6:0]  max_count;
  } in_item_t;

  typedef struct packed {
    logic        event_valid;
    logic [7:0]  out_type;
    logic [31:0] out_payload;
    logic        is_last;
    logic [5:0]  match_total;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: hdl/event_queue_mask_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Event queue with masked extract.
// Input channel in_valid/in_ready/in_data carries one command item: push,
// pop, peek matching or take matching. Output channel out_valid/out_ready/
// out_data carries result items; the last result of a command has is_last.
// Entries live in a chain of DEPTH-1 cells, oldest in cell 0, packed.
// Push and pop: one result, registered in the cycle after the item is taken;
// a new command is taken each cycle while the output register drains.
// Peek and take: the chain rotates by one cell per cycle while the walk is
// not paused, visiting each stored entry once; the final result leaves at the end
// of the walk, earlier matches as the next match shows up.
// When the receiver stalls, the output register holds and the walk pauses
// at a match that needs the register; no command is taken until the
// result register can load.
// Reset empties the queue and clears out_valid; stored entries and
// out_data are not cleared.
module event_queue_mask_filter_unit #(
  parameter int DEPTH     = eqmf_pkg::DEPTH_DEF,
  parameter int PAYLOAD_W = eqmf_pkg::PAYLOAD_W_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire eqmf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output eqmf_pkg::out_item_t      out_data
);

  localparam int N       = DEPTH - 1;
  localparam int CW      = $clog2(DEPTH);
  localparam int ENTRY_W = 8 + PAYLOAD_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       steps;
  logic [31:0]         mask_q;
  logic [5:0]          limit_q;
  logic                take_q;
  logic [5:0]          matched;
  logic                pend_valid;
  logic [7:0]          pend_type;
  logic [31:0]         pend_payload;
  logic [5:0]          pend_total;

  logic [ENTRY_W-1:0]  cell_q [N];
  eqmf_pkg::cell_ctl_t ctl    [N];
  logic [ENTRY_W-1:0]  load_data;
  logic [ENTRY_W-1:0]  push_entry;
  logic [63:0]         push_wide;
  logic [63:0]         head_wide;
  logic [7:0]          head_type;
  logic [31:0]         head_payload;
  logic                can_load;
  logic                accept;
  logic                full;
  logic                hit;
  logic                keep;
  logic                walk_go;
  logic                out_load;

  assign can_load     = !out_valid || out_ready;
  assign in_ready     = (state == S_IDLE) && can_load;
  assign accept       = in_valid && in_ready;
  assign full         = (count == CW'(N));
  assign push_wide    = 64'(in_data.event_payload);
  assign push_entry   = {in_data.event_type, push_wide[PAYLOAD_W-1:0]};
  assign head_type    = cell_q[0][ENTRY_W-1 -: 8];
  assign head_wide    = 64'(cell_q[0][PAYLOAD_W-1:0]);
  assign head_payload = head_wide[31:0];
  assign hit          = (head_type < eqmf_pkg::TYPE_LIMIT) && mask_q[head_type[4:0]]
                        && (matched < limit_q);
  assign keep         = !hit || !take_q;
  // a second match needs the output register to pass on the held one
  assign walk_go      = (state == S_WALK) && !(hit && pend_valid && !can_load);
  assign load_data    = walk_go ? cell_q[0] : push_entry;
  assign out_load     = (accept && (in_data.op == eqmf_pkg::OP_PUSH
                                    || in_data.op == eqmf_pkg::OP_POP))
                        || (walk_go && hit && pend_valid)
                        || ((state == S_FIN) && can_load);

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [ENTRY_W-1:0] right;
    if (i == N - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = cell_q[i+1];
    end
    always_comb begin
      ctl[i].shift = (accept && in_data.op == eqmf_pkg::OP_POP && count != '0)
                     || walk_go;
      ctl[i].load  = (accept && in_data.op == eqmf_pkg::OP_PUSH && !full
                      && count == CW'(i))
                     || (walk_go && keep && count == CW'(i + 1));
    end
    eqmf_cell #(.ENTRY_W(ENTRY_W)) u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .right     (right),
      .load_data (load_data),
      .entry     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.op)
              eqmf_pkg::OP_PUSH: begin
                out_data  <= '{1'b0, 8'd0, 32'd0, 1'b1, 6'd0,
                               full ? eqmf_pkg::ST_FULL : eqmf_pkg::ST_OK};
                if (!full) begin
                  count <= count + CW'(1);
                end
              end
              eqmf_pkg::OP_POP: begin
                if (count == '0) begin
                  out_data <= '{1'b0, 8'd0, 32'd0, 1'b1, 6'd0, eqmf_pkg::ST_EMPTY};
                end else begin
                  out_data <= '{1'b1, head_type, head_payload, 1'b1, 6'd0,
                                eqmf_pkg::ST_OK};
                  count    <= count - CW'(1);
                end
              end
              default: begin
                mask_q     <= in_data.type_mask;
                limit_q    <= (in_data.max_count > 7'(eqmf_pkg::MAX_RESULTS))
                              ? eqmf_pkg::MAX_RESULTS : in_data.max_count[5:0];
                take_q     <= (in_data.op == eqmf_pkg::OP_TAKE);
                matched    <= '0;
                pend_valid <= 1'b0;
                steps      <= count;
                state      <= (count == '0) ? S_FIN : S_WALK;
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_go) begin
            if (hit) begin
              if (pend_valid) begin
                out_data  <= '{1'b1, pend_type, pend_payload, 1'b0, pend_total,
                               eqmf_pkg::ST_OK};
              end
              pend_valid   <= 1'b1;
              pend_type    <= head_type;
              pend_payload <= head_payload;
              pend_total   <= matched + 6'd1;
              matched      <= matched + 6'd1;
            end
            if (!keep) begin
              count <= count - CW'(1);
            end
            steps <= steps - CW'(1);
            if (steps == CW'(1)) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (can_load) begin
            if (pend_valid) begin
              out_data <= '{1'b1, pend_type, pend_payload, 1'b1, pend_total,
                            eqmf_pkg::ST_OK};
            end else begin
              out_data <= '{1'b0, 8'd0, 32'd0, 1'b1, 6'd0, eqmf_pkg::ST_OK};
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/eqmf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module eqmf_cell #(
  parameter int ENTRY_W = 8 + eqmf_pkg::PAYLOAD_W_DEF
) (
  input  wire logic                clk,
  input  wire eqmf_pkg::cell_ctl_t ctl,
  input  wire logic [ENTRY_W-1:0]  right,
  input  wire logic [ENTRY_W-1:0]  load_data,
  output logic      [ENTRY_W-1:0]  entry
);

  // load wins over shift: the last occupied cell takes the recirculated item
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= load_data;
    end else if (ctl.shift) begin
      entry <= right;
    end
  end

endmodule
`default_nettype wire

// File: hdl/eqmf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module eqmf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire eqmf_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire eqmf_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.event_valid |-> out_data.is_last)
    else $error("result without event is not last");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != eqmf_pkg::ST_OK
      |-> out_data.is_last && !out_data.event_valid && out_data.match_total == 6'd0)
    else $error("error status on a non-final or event result");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_valid && out_data.match_total == 6'd0
      |-> out_data.is_last)
    else $error("popped event not marked last");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.op == eqmf_pkg::OP_PEEK
                             || in_data.op == eqmf_pkg::OP_TAKE) |=> !in_ready)
    else $error("item taken during a walk");

endmodule

bind event_queue_mask_filter_unit eqmf_checker u_eqmf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/event_queue_mask_filter_unit_tb.sv
`timescale 1ns / 1ps
module event_queue_mask_filter_unit_tb;

  localparam int RING = 64;
  localparam int CAP = RING - 1;
  localparam int IDLE_LIMIT = 20000;

  class event_queue_board;
    logic [7:0]          q_type[$];
    logic [31:0]         q_pay[$];
    eqmf_pkg::out_item_t pending[$];
    int                  errors;
    int                  checked;

    function void note_command(eqmf_pkg::in_item_t c);
      logic [7:0]  kt[$];
      logic [31:0] kp[$];
      int lim;
      int hits;
      bit hit;
      eqmf_pkg::out_item_t r;
      kt = {};
      kp = {};
      r = '0;
      r.is_last = 1'b1;
      case (c.op)
        eqmf_pkg::OP_PUSH: begin
          if (q_type.size() == CAP) begin
            r.status = eqmf_pkg::ST_FULL;
          end else begin
            q_type.push_back(c.event_type);
            q_pay.push_back(c.event_payload);
          end
          pending.push_back(r);
        end
        eqmf_pkg::OP_POP: begin
          if (q_type.size() == 0) begin
            r.status = eqmf_pkg::ST_EMPTY;
          end else begin
            r.event_valid = 1'b1;
            r.out_type = q_type.pop_front();
            r.out_payload = q_pay.pop_front();
          end
          pending.push_back(r);
        end
        default: begin
          lim = (c.max_count > eqmf_pkg::MAX_RESULTS) ? eqmf_pkg::MAX_RESULTS
                                                      : c.max_count;
          hits = 0;
          foreach (q_type[i]) begin
            hit = (q_type[i] < eqmf_pkg::TYPE_LIMIT) && c.type_mask[q_type[i][4:0]];
            if (hit && hits < lim) begin
              hits++;
              r = '0;
              r.event_valid = 1'b1;
              r.out_type = q_type[i];
              r.out_payload = q_pay[i];
              r.match_total = hits[5:0];
              pending.push_back(r);
              if (c.op == eqmf_pkg::OP_PEEK) begin
                kt.push_back(q_type[i]);
                kp.push_back(q_pay[i]);
              end
            end else begin
              kt.push_back(q_type[i]);
              kp.push_back(q_pay[i]);
            end
          end
          if (hits == 0) begin
            r = '0;
            r.is_last = 1'b1;
            pending.push_back(r);
          end else begin
            pending[pending.size() - 1].is_last = 1'b1;
          end
          q_type = kt;
          q_pay = kp;
        end
      endcase
    endfunction

    function void check_result(eqmf_pkg::out_item_t got);
      eqmf_pkg::out_item_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected v%0b t%h p%h l%0b n%0d s%0d, ",
                    "got v%0b t%h p%h l%0b n%0d s%0d"},
                   want.event_valid, want.out_type, want.out_payload, want.is_last,
                   want.match_total, want.status, got.event_valid, got.out_type,
                   got.out_payload, got.is_last, got.match_total, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  eqmf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  eqmf_pkg::out_item_t out_data;

  event_queue_board board = new();
  int idle_cycles = 0;
  int sent = 0;
  bit timed_out = 1'b0;

  event_queue_mask_filter_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_command(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog: no progress, %0d results outstanding", board.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall before each result, with runs of none
  initial begin : drain
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (($urandom_range(0, 199) < 40) && sent > 200 && sent < 260) w = 0;
      if (w != 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // valid stays up across back-to-back items and drops only before a gap
  task automatic send_cmd(input eqmf_pkg::in_item_t c, input bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 16);
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic eqmf_pkg::in_item_t mk(input logic [1:0] op, input logic [7:0] t,
                                            input logic [31:0] p, input logic [31:0] m,
                                            input logic [6:0] n);
    eqmf_pkg::in_item_t c;
    c.op = op;
    c.event_type = t;
    c.event_payload = p;
    c.type_mask = m;
    c.max_count = n;
    return c;
  endfunction

  function automatic logic [7:0] rand_type();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(32, 255))
                                       : 8'($urandom_range(0, 31));
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  initial begin : stimulus
    eqmf_pkg::in_item_t c;
    int r;
    bit burst;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty cases, extremes, out-of-range types, zero and large counts
    send_cmd(mk(eqmf_pkg::OP_POP, 0, 0, 0, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_PEEK, 0, 0, '1, 64), 0);
    send_cmd(mk(eqmf_pkg::OP_TAKE, 0, 0, '1, 64), 0);
    send_cmd(mk(eqmf_pkg::OP_PUSH, 8'd0, 32'h0, 0, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_PUSH, 8'd31, 32'hFFFF_FFFF, 0, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_PUSH, 8'd32, 32'hA5A5_5A5A, 0, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_PUSH, 8'd255, 32'h5A5A_A5A5, 0, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_PUSH, 8'd7, 32'h1234_5678, 0, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_PEEK, 0, 0, '1, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_PEEK, 0, 0, 32'h0, 64), 0);
    send_cmd(mk(eqmf_pkg::OP_PEEK, 0, 0, '1, 127), 0);
    send_cmd(mk(eqmf_pkg::OP_TAKE, 0, 0, 32'h8000_0001, 1), 0);
    send_cmd(mk(eqmf_pkg::OP_TAKE, 0, 0, '1, 127), 0);
    send_cmd(mk(eqmf_pkg::OP_POP, 0, 0, 0, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_POP, 0, 0, 0, 0), 0);
    send_cmd(mk(eqmf_pkg::OP_POP, 0, 0, 0, 0), 0);
    // fill until full, then a full push, then a full-length peek
    for (int i = 0; i < CAP + 1; i++)
      send_cmd(mk(eqmf_pkg::OP_PUSH, 8'(i % 33), $urandom, 0, 0), 1);
    send_cmd(mk(eqmf_pkg::OP_PEEK, 0, 0, '1, 127), 0);
    wait_drained();
    send_cmd(mk(eqmf_pkg::OP_TAKE, 0, 0, $urandom, 7'($urandom_range(0, 64))), 0);
    // random part: half pushes, the rest pops and filtered extracts
    while (sent < 430) begin
      r = $urandom_range(0, 99);
      burst = ($urandom_range(0, 7) == 0);
      c = mk(eqmf_pkg::OP_PUSH, rand_type(), $urandom, $urandom,
             7'($urandom_range(0, 64)));
      if (r < 50) c.op = eqmf_pkg::OP_PUSH;
      else if (r < 65) c.op = eqmf_pkg::OP_POP;
      else if (r < 80) c.op = eqmf_pkg::OP_PEEK;
      else c.op = eqmf_pkg::OP_TAKE;
      if ($urandom_range(0, 9) == 0) c.type_mask = '1;
      if ($urandom_range(0, 9) == 0) c.max_count = 7'($urandom_range(65, 127));
      send_cmd(c, burst);
      if (sent == 300) wait_drained();
    end
    wait_drained();
    $display("ran %0d commands (push, pop, peek, take incl. full, empty and no-match cases)",
             sent);
    $display("checked %0d results, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
